### hdl/preamble_length_crc_deframer_unit_assert.svh
// Assertion macros for the preamble/length/CRC deframer.
`ifndef PREAMBLE_LENGTH_CRC_DEFRAMER_UNIT_ASSERT_SVH
`define PREAMBLE_LENGTH_CRC_DEFRAMER_UNIT_ASSERT_SVH

// Property must hold on every clock edge outside reset.
`define PLCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define PLCD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### hdl/plcd_pkg.sv
// Types, codes and the CRC-32 byte step shared by the deframer.
`default_nettype none
package plcd_pkg;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_CRC     = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_GOOD     = 3'd1,
		EV_TOO_LONG = 3'd2,
		EV_CRC_BAD  = 3'd3,
		EV_ID_RANGE = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		REG_PREAMBLE = 2'd0,
		REG_CAPACITY = 2'd1,
		REG_ID_LOW   = 2'd2,
		REG_ID_HIGH  = 2'd3
	} reg_index_t;

	localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;
	localparam logic [31:0] PREAMBLE_RESET = 32'h0000_0000;
	localparam logic [15:0] CAPACITY_RESET = 16'd1024;
	localparam logic [7:0]  ID_LOW_RESET   = 8'd1;
	localparam logic [7:0]  ID_HIGH_RESET  = 8'd11;
	// preamble, header and CRC overhead added to the length before the capacity check
	localparam logic [16:0] FRAME_OVERHEAD = 17'd11;

	// Reflected CRC-32 over one byte, eight shift steps.
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### hdl/preamble_length_crc_deframer_unit.sv
// Top level of the preamble/length/CRC-32 stream deframer.
// Stage 1 registers the accepted input word, stage 2 its result word on the master side.
// Throughput: one byte per cycle; the CRC byte step and the phase update are one stage.
// Each input word yields exactly one result word; back-pressure stalls both stages.
// Reset (arst_n low, asynchronous): registers return to their defaults, hunt restarts,
// both stages empty. No clearing pass; the block takes words straight after reset.
`default_nettype none
`include "preamble_length_crc_deframer_unit_assert.svh"
module preamble_length_crc_deframer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// receive byte stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] rx_byte
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,  // [7:0] msg_id, [23:8] frame_len, [31:24] payload_byte,
	                                   // [47:32] payload_index, [79:48] computed_crc
	output logic [3:0]       m_tuser,  // [2:0] event_res, [3] payload_valid
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	// ---------------- configuration registers ----------------
	logic [31:0] preamble_q;
	logic [15:0] capacity_q;
	logic [7:0]  id_low_q;
	logic [7:0]  id_high_q;

	// writes are taken at any time; the user writes only while idle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= plcd_pkg::PREAMBLE_RESET;
			capacity_q <= plcd_pkg::CAPACITY_RESET;
			id_low_q   <= plcd_pkg::ID_LOW_RESET;
			id_high_q  <= plcd_pkg::ID_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (plcd_pkg::reg_index_t'(cfg_index))
				plcd_pkg::REG_PREAMBLE: preamble_q <= cfg_data;
				plcd_pkg::REG_CAPACITY: capacity_q <= cfg_data[15:0];
				plcd_pkg::REG_ID_LOW:   id_low_q   <= cfg_data[7:0];
				plcd_pkg::REG_ID_HIGH:  id_high_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// ---------------- stage 1: input register ----------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	logic       advance;   // stage 1 word moves into the result register

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// ---------------- deframer state ----------------
	plcd_pkg::phase_t phase_q, phase_d;
	logic [1:0]  match_q, match_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  frame_id_q, frame_id_d;
	logic [15:0] frame_len_q, frame_len_d;
	logic [31:0] crc_q, crc_d;
	logic [31:0] rx_crc_q, rx_crc_d;

	logic [31:0] crc_step;     // running CRC advanced by the stage 1 byte
	logic [7:0]  want_byte;    // preamble byte expected at match_q
	logic [15:0] len_full;     // length once its high byte arrives
	logic        too_long;
	logic [31:0] rx_crc_lane;  // received CRC with the stage 1 byte merged in
	logic [15:0] count_inc;

	assign crc_step  = plcd_pkg::crc32_byte(crc_q, byte_s1);
	assign len_full  = {byte_s1, frame_len_q[7:0]};
	assign too_long  = ({1'b0, len_full} + plcd_pkg::FRAME_OVERHEAD) > {1'b0, capacity_q};
	assign count_inc = count_q + 16'd1;

	always_comb begin
		case (match_q)
			2'd0:    want_byte = preamble_q[7:0];
			2'd1:    want_byte = preamble_q[15:8];
			2'd2:    want_byte = preamble_q[23:16];
			default: want_byte = preamble_q[31:24];
		endcase
	end

	always_comb begin
		case (count_q[1:0])
			2'd0:    rx_crc_lane = rx_crc_q | {24'd0, byte_s1};
			2'd1:    rx_crc_lane = rx_crc_q | {16'd0, byte_s1, 8'd0};
			2'd2:    rx_crc_lane = rx_crc_q | {8'd0, byte_s1, 16'd0};
			default: rx_crc_lane = rx_crc_q | {byte_s1, 24'd0};
		endcase
	end

	// next state
	always_comb begin
		phase_d     = phase_q;
		match_d     = match_q;
		count_d     = count_q;
		frame_id_d  = frame_id_q;
		frame_len_d = frame_len_q;
		crc_d       = crc_q;
		rx_crc_d    = rx_crc_q;
		case (phase_q)
			plcd_pkg::PH_HUNT: begin
				if (byte_s1 == want_byte) begin
					crc_d   = crc_step;
					match_d = match_q + 2'd1;   // wraps to zero after the last byte
					if (match_q == 2'd3) begin
						count_d = 16'd0;
						phase_d = plcd_pkg::PH_HEADER;
					end
				end else begin
					// restart; this byte is not retried as a first preamble byte
					match_d = 2'd0;
					count_d = 16'd0;
					crc_d   = plcd_pkg::CRC_INIT;
				end
			end
			plcd_pkg::PH_HEADER: begin
				crc_d = crc_step;
				if (count_q[1:0] == 2'd0) begin
					frame_id_d = byte_s1;
					count_d    = 16'd1;
				end else if (count_q[1:0] == 2'd1) begin
					frame_len_d = {8'd0, byte_s1};
					count_d     = 16'd2;
				end else begin
					frame_len_d = len_full;
					if (too_long) begin
						phase_d = plcd_pkg::PH_HUNT;
						match_d = 2'd0;
						count_d = 16'd0;
						crc_d   = plcd_pkg::CRC_INIT;
					end else begin
						count_d  = 16'd0;
						rx_crc_d = 32'd0;
						phase_d  = (len_full == 16'd0) ? plcd_pkg::PH_CRC : plcd_pkg::PH_PAYLOAD;
					end
				end
			end
			plcd_pkg::PH_PAYLOAD: begin
				crc_d   = crc_step;
				count_d = count_inc;
				if (count_inc >= frame_len_q) begin
					count_d  = 16'd0;
					rx_crc_d = 32'd0;
					phase_d  = plcd_pkg::PH_CRC;
				end
			end
			default: begin
				rx_crc_d = rx_crc_lane;
				if (count_q[1:0] == 2'd3) begin
					phase_d = plcd_pkg::PH_HUNT;
					match_d = 2'd0;
					count_d = 16'd0;
					crc_d   = plcd_pkg::CRC_INIT;
				end else begin
					count_d = {14'd0, count_q[1:0] + 2'd1};
				end
			end
		endcase
	end

	// result fields for the stage 1 byte
	plcd_pkg::event_t ev_d;
	logic        pv_d;
	logic [7:0]  pb_d;
	logic [15:0] pi_d;
	logic [31:0] cc_d;

	always_comb begin
		ev_d = plcd_pkg::EV_NONE;
		pv_d = 1'b0;
		pb_d = 8'd0;
		pi_d = 16'd0;
		cc_d = 32'd0;
		case (phase_q)
			plcd_pkg::PH_HEADER: begin
				if (count_q[1:0] != 2'd0 && count_q[1:0] != 2'd1 && too_long) begin
					ev_d = plcd_pkg::EV_TOO_LONG;
					cc_d = ~crc_step;
				end
			end
			plcd_pkg::PH_PAYLOAD: begin
				pv_d = 1'b1;
				pb_d = byte_s1;
				pi_d = count_q;
			end
			plcd_pkg::PH_CRC: begin
				if (count_q[1:0] == 2'd3) begin
					cc_d = ~crc_q;
					if (rx_crc_lane != ~crc_q) begin
						ev_d = plcd_pkg::EV_CRC_BAD;
					end else if (frame_id_q < id_low_q || frame_id_q > id_high_q) begin
						ev_d = plcd_pkg::EV_ID_RANGE;
					end else begin
						ev_d = plcd_pkg::EV_GOOD;
					end
				end
			end
			default: ;
		endcase
	end

	// advance the deframer state once per byte leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= plcd_pkg::PH_HUNT;
			match_q     <= 2'd0;
			count_q     <= 16'd0;
			frame_id_q  <= 8'd0;
			frame_len_q <= 16'd0;
			crc_q       <= plcd_pkg::CRC_INIT;
			rx_crc_q    <= 32'd0;
		end else if (advance) begin
			phase_q     <= phase_d;
			match_q     <= match_d;
			count_q     <= count_d;
			frame_id_q  <= frame_id_d;
			frame_len_q <= frame_len_d;
			crc_q       <= crc_d;
			rx_crc_q    <= rx_crc_d;
		end
	end

	// ---------------- stage 2: result register ----------------
	plcd_pkg::event_t ev_s2;
	logic        pv_s2;
	logic [7:0]  id_s2;
	logic [15:0] len_s2;
	logic [7:0]  pb_s2;
	logic [15:0] pi_s2;
	logic [31:0] cc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ev_s2  <= ev_d;
			pv_s2  <= pv_d;
			id_s2  <= frame_id_d;
			len_s2 <= frame_len_d;
			pb_s2  <= pb_d;
			pi_s2  <= pi_d;
			cc_s2  <= cc_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {cc_s2, pi_s2, pb_s2, len_s2, id_s2};
	assign m_tuser  = {pv_s2, ev_s2};

	// ---------------- checks ----------------
	`PLCD_ASSERT(a_payload_no_event,
		valid_s2 && pv_s2 |-> ev_s2 == plcd_pkg::EV_NONE,
		"payload word carries an event")
	`PLCD_ASSERT(a_event_back_to_hunt,
		advance && ev_d != plcd_pkg::EV_NONE |=> phase_q == plcd_pkg::PH_HUNT,
		"frame event without return to preamble hunt")
	`PLCD_ASSERT(a_crc_only_with_event,
		valid_s2 && ev_s2 == plcd_pkg::EV_NONE |-> cc_s2 == 32'd0,
		"computed CRC shown without an event")
	`PLCD_ASSERT_NEVER(a_payload_count_range,
		phase_q == plcd_pkg::PH_PAYLOAD && count_q >= frame_len_q,
		"payload count reached frame length")

endmodule
`default_nettype wire

### sim/plcd_frame_checker.sv
// Frame checker for the deframer: predicts each result word and compares it with the block.
package plcd_check_pkg;

	localparam logic [31:0] FCS_POLY = 32'hEDB8_8320;

	// Advance a reflected CRC-32 by one byte, one data bit at a time.
	function automatic logic [31:0] crc32_next(input logic [31:0] acc, input logic [7:0] d);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = acc[0] ^ d[i];
			acc = acc >> 1;
			if (fb)
				acc = acc ^ FCS_POLY;
		end
		return acc;
	endfunction

endpackage

module plcd_frame_checker
	import plcd_pkg::*;
	import plcd_check_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,
	input  logic [3:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          open_words,
	output int          fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [16:0] FRAME_EXTRA = 17'd11;

	typedef struct packed {
		event_t      ev;
		logic [7:0]  id;
		logic [15:0] len;
		logic        pv;
		logic [7:0]  pb;
		logic [15:0] pidx;
		logic [31:0] fcs;
	} deframe_word_t;

	deframe_word_t expected_words[$];
	deframe_word_t next_word;
	deframe_word_t oldest;

	logic [31:0] pre_word;
	logic [15:0] capacity;
	logic [7:0]  id_lo;
	logic [7:0]  id_hi;

	phase_t      phase;
	logic [1:0]  match_idx;
	logic [15:0] count;
	logic [7:0]  fid;
	logic [15:0] flen;
	logic [31:0] crc_acc;
	logic [31:0] rx_fcs;

	initial fail_count = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic restart_hunt();
		phase = PH_HUNT;
		match_idx = 2'd0;
		count = 16'd0;
		crc_acc = 32'hFFFF_FFFF;
	endtask

	task automatic decode_byte(input logic [7:0] b, output deframe_word_t w);
		w = '0;
		w.ev = EV_NONE;
		case (phase)
			PH_HUNT: begin
				if (b == pre_word[{match_idx, 3'b000} +: 8]) begin
					crc_acc = crc32_next(crc_acc, b);
					if (match_idx == 2'd3) begin
						match_idx = 2'd0;
						count = 16'd0;
						phase = PH_HEADER;
					end else begin
						match_idx = match_idx + 2'd1;
					end
				end else begin
					restart_hunt();
				end
			end
			PH_HEADER: begin
				crc_acc = crc32_next(crc_acc, b);
				if (count == 16'd0) begin
					fid = b;
					count = 16'd1;
				end else if (count == 16'd1) begin
					flen = {8'd0, b};
					count = 16'd2;
				end else begin
					flen[15:8] = b;
					if ({1'b0, flen} + FRAME_EXTRA > {1'b0, capacity}) begin
						w.ev = EV_TOO_LONG;
						w.fcs = ~crc_acc;
						restart_hunt();
					end else begin
						count = 16'd0;
						rx_fcs = 32'd0;
						phase = (flen == 16'd0) ? PH_CRC : PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				crc_acc = crc32_next(crc_acc, b);
				w.pv = 1'b1;
				w.pb = b;
				w.pidx = count;
				count = count + 16'd1;
				if (count >= flen) begin
					count = 16'd0;
					rx_fcs = 32'd0;
					phase = PH_CRC;
				end
			end
			default: begin
				rx_fcs = rx_fcs | ({24'd0, b} << {count[1:0], 3'b000});
				if (count[1:0] == 2'd3) begin
					w.fcs = ~crc_acc;
					// CRC verdict wins over the id range test
					if (rx_fcs != ~crc_acc)
						w.ev = EV_CRC_BAD;
					else if (fid < id_lo || fid > id_hi)
						w.ev = EV_ID_RANGE;
					else
						w.ev = EV_GOOD;
					restart_hunt();
				end else begin
					count = {14'd0, count[1:0] + 2'd1};
				end
			end
		endcase
		w.id = fid;
		w.len = flen;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_word = 32'd0;
			capacity = 16'd1024;
			id_lo = 8'd1;
			id_hi = 8'd11;
			fid = 8'd0;
			flen = 16'd0;
			rx_fcs = 32'd0;
			restart_hunt();
			expected_words.delete();
			open_words <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_index_t'(cfg_index))
					REG_PREAMBLE: pre_word = cfg_data;
					REG_CAPACITY: capacity = cfg_data[15:0];
					REG_ID_LOW:   id_lo = cfg_data[7:0];
					REG_ID_HIGH:  id_hi = cfg_data[7:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					report("result word with none expected", m_tdata[31:0], 32'd0);
				end else begin
					oldest = expected_words.pop_front();
					if (m_tuser[2:0] != oldest.ev)
						report("event_res", 32'(m_tuser[2:0]), 32'(oldest.ev));
					if (m_tuser[3] != oldest.pv)
						report("payload_valid", 32'(m_tuser[3]), 32'(oldest.pv));
					if (m_tdata[7:0] != oldest.id)
						report("msg_id", 32'(m_tdata[7:0]), 32'(oldest.id));
					if (m_tdata[23:8] != oldest.len)
						report("frame_len", 32'(m_tdata[23:8]), 32'(oldest.len));
					if (m_tdata[31:24] != oldest.pb)
						report("payload_byte", 32'(m_tdata[31:24]), 32'(oldest.pb));
					if (m_tdata[47:32] != oldest.pidx)
						report("payload_index", 32'(m_tdata[47:32]), 32'(oldest.pidx));
					if (m_tdata[79:48] != oldest.fcs)
						report("computed_crc", m_tdata[79:48], oldest.fcs);
				end
			end
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, next_word);
				expected_words.push_back(next_word);
			end
			open_words <= expected_words.size();
		end
	end

endmodule

### sim/preamble_length_crc_deframer_unit_test.sv
// Testbench top for the deframer: clock, reset, byte and register stimulus, verdict.
module preamble_length_crc_deframer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import plcd_pkg::*;
	import plcd_check_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [31:0] cfg_data = 32'd0;

	int open_words;
	int fail_count;

	// settings the frame builder works against
	logic [31:0] cur_pre;
	int          cur_cap;
	int          cur_lo;
	int          cur_hi;

	bit calm = 1'b0;   // no idling on either side while set
	int bytes_sent = 0;
	int hold_left = 0;

	preamble_length_crc_deframer_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	plcd_frame_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.open_words(open_words),
		.fail_count(fail_count)
	);

	always #5 clk = ~clk;

	// Gap length: mostly none, some short, a few long.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Result side: hold tready low for random stretches.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!calm && $urandom_range(0, 99) < 30) begin
			m_tready <= 1'b0;
			hold_left <= idle_length();
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offer one byte, after an optional gap, and hold it until taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = idle_length();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// Drop valid and wait until every result word has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (open_words != 0);
	endtask

	// Hold one register write until taken; the caller drops valid after the last one.
	task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Registers change only with the block idle; every register is written each time.
	task automatic apply_setting(input logic [31:0] pre, input int cap, input int lo, input int hi);
		drain();
		write_reg(REG_PREAMBLE, pre);
		write_reg(REG_CAPACITY, cap);
		write_reg(REG_ID_LOW, lo);
		write_reg(REG_ID_HIGH, hi);
		cfg_valid <= 1'b0;
		cur_pre = pre;
		cur_cap = cap;
		cur_lo = lo;
		cur_hi = hi;
	endtask

	// Send preamble, id and length; then, unless header_only, payload and the
	// little-endian CRC with crc_flip xored in to spoil it on purpose.
	task automatic send_frame(input logic [7:0] id, input logic [15:0] len,
			input logic [31:0] crc_flip, input bit header_only);
		logic [31:0] acc;
		logic [31:0] fcs;
		logic [7:0]  b;
		acc = 32'hFFFF_FFFF;
		for (int i = 0; i < 7; i++) begin
			if (i < 4)
				b = cur_pre[8*i +: 8];
			else if (i == 4)
				b = id;
			else
				b = len[8*(i-5) +: 8];
			acc = crc32_next(acc, b);
			send_byte(b);
		end
		if (!header_only) begin
			for (int i = 0; i < len; i++) begin
				b = 8'($urandom_range(0, 255));
				acc = crc32_next(acc, b);
				send_byte(b);
			end
			fcs = ~acc ^ crc_flip;
			for (int i = 0; i < 4; i++)
				send_byte(fcs[8*i +: 8]);
		end
	endtask

	function automatic logic [7:0] pick_id();
		if (cur_lo <= cur_hi && $urandom_range(0, 99) < 75)
			return 8'($urandom_range(cur_lo, cur_hi));
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly well-formed frames with random content, the rest noise and broken ones.
	task automatic run_random(input int n, input bit mid_pause);
		int start;
		int kind;
		int len;
		int k;
		bit paused;
		start = bytes_sent;
		paused = 1'b0;
		while (bytes_sent - start < n) begin
			kind = $urandom_range(0, 99);
			if (kind < 55 || kind < 65) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
				if (len > cur_cap - 11)
					len = cur_cap - 11;
				// the second band spoils the CRC in one random bit
				send_frame(pick_id(), 16'(len),
					(kind < 55) ? 32'd0 : (32'd1 << $urandom_range(0, 31)), 1'b0);
			end else if (kind < 77) begin
				// length just over the limit, or the largest
				len = cur_cap - 10 + $urandom_range(0, 20);
				if (len > 65535 || $urandom_range(0, 4) == 0)
					len = 65535;
				send_frame(pick_id(), 16'(len), 32'd0, 1'b1);
			end else if (kind < 89) begin
				// preamble broken after up to three good bytes
				k = $urandom_range(0, 3);
				for (int i = 0; i < k; i++)
					send_byte(cur_pre[8*i +: 8]);
				send_byte(cur_pre[8*k +: 8] ^ 8'($urandom_range(1, 255)));
			end else begin
				k = $urandom_range(1, 6);
				repeat (k) send_byte(8'($urandom_range(0, 255)));
			end
			if (mid_pause && !paused && bytes_sent - start >= n / 2) begin
				drain();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		cur_pre = 32'd0;
		cur_cap = 1024;
		cur_lo = 1;
		cur_hi = 11;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with reset settings: a preamble broken on its second byte
		// (the breaking byte is not retried as a first byte), then a zero-length
		// frame whose id is out of range, a frame of the largest length, and a
		// frame with a spoilt CRC.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(8'hFF, 16'd0, 32'd0, 1'b0);
		send_frame(8'd5, 16'hFFFF, 32'd0, 1'b1);
		send_frame(8'd1, 16'd1, 32'h8000_0000, 1'b0);

		apply_setting($urandom, 1024, 1, 11);
		run_random(100, 1'b0);

		// smallest buffer: only zero-length frames fit; no idling at all
		calm = 1'b1;
		apply_setting(32'hFFFF_FFFF, 11, 0, 255);
		run_random(100, 1'b0);
		calm = 1'b0;

		// largest buffer, crossed id bounds: every id is out of range
		apply_setting(32'h0000_0000, 65535, 255, 0);
		run_random(100, 1'b1);

		// repeated preamble byte, single accepted id
		apply_setting(32'hA5A5_A5A5, 40, 7, 7);
		run_random(100, 1'b0);

		apply_setting($urandom, $urandom_range(11, 200), $urandom_range(0, 255),
			$urandom_range(0, 255));
		run_random(100, 1'b0);

		apply_setting($urandom, $urandom_range(11, 65535), $urandom_range(0, 255),
			$urandom_range(0, 255));
		run_random(100, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("preamble_length_crc_deframer_unit verification clean");
		else
			$display("preamble_length_crc_deframer_unit verification failed");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5_000_000;
		$display("preamble_length_crc_deframer_unit verification failed");
		$finish;
	end

endmodule
